[rtl/core/c8x_pkg.sv]
// Package for the CHIP-8 instruction executor: widths, constants, codes and types.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
package c8x_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int ADDR_W        = 12;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam logic [ADDR_W-1:0] PROGRAM_START = 12'h200;
    localparam logic [ADDR_W-1:0] FETCH_LIMIT   = 12'hFFF;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_REG   = 2'd3;

    // Memory port command from the sequencer.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_cmd;

    // Hundreds, tens and units of a byte, worked out by constant reciprocal.
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [15:0] q;
        logic [7:0]  h;
        logic [7:0]  r;
        logic [7:0]  t;
        logic [7:0]  u;
        q = 16'(v) * 16'd41;
        h = 8'(q >> 12);
        r = 8'(v - 8'(h * 8'd100));
        q = 16'(r) * 16'd205;
        t = 8'(q >> 11);
        u = 8'(r - 8'(t * 8'd10));
        return {h[3:0], t[3:0], u[3:0]};
    endfunction

endpackage

[rtl/core/c8x_memory.sv]
// Byte memory of the executor: 4 KB, one read/write port, registered read data.
// Depends on c8x_pkg.
`timescale 1ns / 1ps
module c8x_memory (
    input  logic              i_clk,
    input  c8x_pkg::t_mem_cmd i_cmd,
    output logic [7:0]        o_rdata
);
    logic [7:0] r_mem [c8x_pkg::MEM_BYTES];

    // Writes if requested; read data is registered and on a write holds the old byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        o_rdata <= r_mem[i_cmd.addr];
    end
endmodule

[rtl/core/c8x_stack.sv]
// Call stack of return addresses, a small synchronous memory.
// Depends on c8x_pkg.
`timescale 1ns / 1ps
module c8x_stack (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [c8x_pkg::SP_W-1:0]        i_addr,
    input  logic [c8x_pkg::ADDR_W-1:0]      i_wdata,
    output logic [c8x_pkg::ADDR_W-1:0]      o_rdata
);
    logic [c8x_pkg::ADDR_W-1:0] r_stk [c8x_pkg::STACK_DEPTH];

    // Registered read at the given slot.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_stk[i_addr] <= i_wdata;
        end
        o_rdata <= r_stk[i_addr];
    end
endmodule

[rtl/core/chip8_instruction_executor.sv]
// Top level of the CHIP-8 instruction executor: sequencer, registers, timers.
// Depends on c8x_pkg, c8x_memory and c8x_stack.
//
// Channel   Direction  Handshake            Contents
// cfg       in         i_cfg_valid/ready    program end (13 bits)
// in        in         i_valid/o_ready      mode, address, write byte
// out       out        o_valid/i_ready      status, registers, flags
//
// A fetching run reads the two opcode bytes on the single memory port, then executes
// and gives the result; a return adds a stack read and FX33 adds the tens and units
// writes. Reset is synchronous and sets PC to 0x200. A new request is taken only once
// the previous result has been taken.
`timescale 1ns / 1ps
module chip8_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_program_end,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_executed,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_fetched_opcode,
    output logic [11:0] o_index_value,
    output logic [7:0]  o_read_value,
    output logic [7:0]  o_delay_count,
    output logic [7:0]  o_sound_count,
    output logic        o_beep,
    output logic        o_clear_screen,
    output logic        o_unknown_opcode
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_FHI  = 8'b00000010,
        S_FLO  = 8'b00000100,
        S_EXEC = 8'b00001000,
        S_RET  = 8'b00010000,
        S_BCD1 = 8'b00100000,
        S_BCD2 = 8'b01000000,
        S_RD   = 8'b10000000
    } t_state;

    t_state             r_state, n_state;
    logic [12:0]        r_pend;
    logic [11:0]        r_pc, r_i, r_addr;
    logic [15:0]        r_op;
    logic [7:0]         r_dt, r_st, r_v [16];
    logic [c8x_pkg::SP_W-1:0] r_sp;
    logic [11:0]        r_digits;
    logic               r_out_v, r_exe, r_beep, r_clr, r_unk;
    logic [7:0]         r_rd;
    logic               r_regrd;

    c8x_pkg::t_mem_cmd  s_cmd;
    logic [7:0]         s_mdata;
    logic               s_stk_we;
    logic [c8x_pkg::SP_W-1:0] s_stk_addr;
    logic [11:0]        s_stk_rdata;

    c8x_memory u_mem (.i_clk(i_clk), .i_cmd(s_cmd), .o_rdata(s_mdata));
    c8x_stack  u_stk (.i_clk(i_clk), .i_we(s_stk_we), .i_addr(s_stk_addr),
                      .i_wdata(12'(r_pc + 12'd2)), .o_rdata(s_stk_rdata));

    function automatic logic SPDEC(input logic [c8x_pkg::SP_W-1:0] sp);
        return sp == '0;
    endfunction

    // Opcode fields.
    logic [3:0]  s_x, s_y, s_hi, s_lo;
    logic [7:0]  s_nn, s_vx, s_vy;
    logic [11:0] s_nnn, s_next;
    logic [8:0]  s_sum;
    logic [11:0] s_digits;
    logic [7:0]  s_dt_x, s_st_x;
    logic        s_accept, s_go, s_sp_dec;
    assign s_hi  = r_op[15:12];
    assign s_x   = r_op[11:8];
    assign s_y   = r_op[7:4];
    assign s_lo  = r_op[3:0];
    assign s_nn  = r_op[7:0];
    assign s_nnn = r_op[11:0];
    assign s_vx  = r_v[s_x];
    assign s_vy  = r_v[s_y];
    assign s_next = 12'(r_pc + 12'd2);
    assign s_sum  = 9'(s_vx) + 9'(s_vy);
    assign s_digits = c8x_pkg::bcd_digits(s_vx);
    assign s_accept = i_valid && o_ready;
    assign s_go = (r_pc < c8x_pkg::FETCH_LIMIT) && (13'(r_pc) < r_pend);
    assign s_sp_dec = SPDEC(r_sp);

    // Timer values after a timer load, before this cycle's decrement.
    always_comb begin
        s_dt_x = r_dt;
        s_st_x = r_st;
        if (s_hi == 4'hF && s_nn == 8'h15) s_dt_x = s_vx;
        if (s_hi == 4'hF && s_nn == 8'h18) s_st_x = s_vx;
    end

    assign o_ready     = (r_state == S_IDLE) && !r_out_v;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_v;

    // Stack address: the pointer, or the slot below it for a return.
    always_comb begin
        s_stk_we   = (r_state == S_EXEC) && (s_hi == 4'h2);
        s_stk_addr = r_sp;
        if (r_state == S_EXEC && s_hi == 4'h0 && s_nnn == 12'h0EE) begin
            s_stk_addr = s_sp_dec ? c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH - 1)
                                  : r_sp - 1'b1;
        end
    end

    // Memory port selection and next state.
    always_comb begin
        s_cmd.we    = 1'b0;
        s_cmd.addr  = r_pc;
        s_cmd.wdata = 8'd0;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    s_cmd.addr = i_address;
                    case (i_mode)
                        c8x_pkg::MODE_WRITE: begin
                            s_cmd.we = 1'b1; s_cmd.wdata = i_write_byte;
                            n_state = S_IDLE;
                        end
                        c8x_pkg::MODE_RUN: begin
                            s_cmd.addr = r_pc;
                            n_state = s_go ? S_FHI : S_IDLE;
                        end
                        default: n_state = S_RD;
                    endcase
                end
            end
            S_FHI: begin s_cmd.addr = 12'(r_pc + 12'd1); n_state = S_FLO; end
            S_FLO: n_state = S_EXEC;
            S_EXEC: begin
                if (s_hi == 4'hF && s_nn == 8'h33) begin
                    s_cmd.we = 1'b1; s_cmd.addr = r_i;
                    s_cmd.wdata = {4'd0, s_digits[11:8]};
                    n_state = S_BCD1;
                end else if (s_hi == 4'h0 && s_nnn == 12'h0EE) begin
                    n_state = S_RET;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BCD1: begin
                s_cmd.we = 1'b1; s_cmd.addr = 12'(r_addr + 12'd1);
                s_cmd.wdata = {4'd0, r_digits[7:4]}; n_state = S_BCD2;
            end
            S_BCD2: begin
                s_cmd.we = 1'b1; s_cmd.addr = 12'(r_addr + 12'd2);
                s_cmd.wdata = {4'd0, r_digits[3:0]}; n_state = S_IDLE;
            end
            S_RET: n_state = S_IDLE;
            S_RD:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer, architectural registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 13'd0;
            r_pc    <= c8x_pkg::PROGRAM_START;
            r_i     <= 12'd0;
            r_op    <= 16'd0;
            r_dt    <= 8'd0;
            r_st    <= 8'd0;
            r_sp    <= '0;
            r_out_v <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_pend <= i_cfg_program_end;
            if (o_valid && i_ready) r_out_v <= 1'b0;
            if (s_accept) begin
                r_exe <= 1'b0; r_beep <= 1'b0; r_clr <= 1'b0; r_unk <= 1'b0;
                r_rd  <= 8'd0; r_addr <= i_address;
                r_regrd <= (i_mode == c8x_pkg::MODE_REG);
                if (i_mode == c8x_pkg::MODE_WRITE ||
                    (i_mode == c8x_pkg::MODE_RUN && !s_go)) r_out_v <= 1'b1;
            end
            case (r_state)
                S_FHI: r_op[15:8] <= s_mdata;
                S_FLO: r_op[7:0]  <= s_mdata;
                S_RD: begin
                    r_rd <= r_regrd ? r_v[r_addr[3:0]] : s_mdata;
                    r_out_v <= 1'b1;
                end
                S_RET: begin
                    r_pc <= s_stk_rdata;
                    r_out_v <= 1'b1;
                end
                S_EXEC: begin
                    r_exe <= 1'b1;
                    r_pc  <= s_next;
                    r_addr <= r_i;
                    r_digits <= s_digits;
                    // BCD and return finish in later states.
                    if (!(s_nn == 8'h33 && s_hi == 4'hF) &&
                        !(s_hi == 4'h0 && s_nnn == 12'h0EE)) r_out_v <= 1'b1;
                    r_dt <= (s_dt_x != 8'd0) ? s_dt_x - 8'd1 : s_dt_x;
                    r_st <= (s_st_x != 8'd0) ? s_st_x - 8'd1 : s_st_x;
                    r_beep <= (s_st_x == 8'd1);
                    case (s_hi)
                        4'h0: begin
                            if (s_nnn == 12'h0E0) r_clr <= 1'b1;
                            else if (s_nnn == 12'h0EE)
                                r_sp <= s_stk_addr;
                        end
                        4'h1: r_pc <= s_nnn;
                        4'h2: begin
                            r_sp <= (32'(r_sp) + 1 >= c8x_pkg::STACK_DEPTH)
                                    ? '0 : r_sp + 1'b1;
                            r_pc <= s_nnn;
                        end
                        4'h3: if (s_vx == s_nn) r_pc <= 12'(s_next + 12'd2);
                        4'h4: if (s_vx != s_nn) r_pc <= 12'(s_next + 12'd2);
                        4'h5: if (s_vx == s_vy) r_pc <= 12'(s_next + 12'd2);
                        4'h9: if (s_vx != s_vy) r_pc <= 12'(s_next + 12'd2);
                        4'h6: r_v[s_x] <= s_nn;
                        4'h7: r_v[s_x] <= 8'(s_vx + s_nn);
                        4'h8: begin
                            case (s_lo)
                                4'h0: r_v[s_x] <= s_vy;
                                4'h1: r_v[s_x] <= s_vx | s_vy;
                                4'h2: r_v[s_x] <= s_vx & s_vy;
                                4'h3: r_v[s_x] <= s_vx ^ s_vy;
                                4'h4: begin
                                    r_v[s_x] <= s_sum[7:0];
                                    r_v[15]  <= {7'd0, s_sum[8]};
                                end
                                4'h6: begin
                                    r_v[s_x] <= {1'b0, s_vx[7:1]};
                                    r_v[15]  <= {7'd0, s_vx[0]};
                                end
                                4'hE: begin
                                    r_v[s_x] <= {s_vx[6:0], 1'b0};
                                    r_v[15]  <= {7'd0, s_vx[7]};
                                end
                                4'h5, 4'h7: ;
                                default: r_unk <= 1'b1;
                            endcase
                        end
                        4'hA: r_i <= s_nnn;
                        4'hE: if (s_nn != 8'h9E && s_nn != 8'hA1) r_unk <= 1'b1;
                        4'hF: begin
                            case (s_nn)
                                8'h07: r_v[s_x] <= r_dt;
                                8'h1E: r_i <= 12'(r_i + 12'(s_vx));
                                8'h15, 8'h18, 8'h33, 8'h0A, 8'h29, 8'h55, 8'h65: ;
                                default: r_unk <= 1'b1;
                            endcase
                        end
                        default: ;
                    endcase
                end
                S_BCD2: r_out_v <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_executed        = r_exe;
    assign o_program_counter = r_pc;
    assign o_fetched_opcode  = r_op;
    assign o_index_value     = r_i;
    assign o_read_value      = r_rd;
    assign o_delay_count     = r_dt;
    assign o_sound_count     = r_st;
    assign o_beep            = r_beep;
    assign o_clear_screen    = r_clr;
    assign o_unknown_opcode  = r_unk;
endmodule

[test/chip8_instruction_executor_chk.sv]
// Checker for the CHIP-8 instruction executor: watches the request, result and
// program-end channels, predicts every result and compares it. Depends on c8x_pkg.
`timescale 1ns / 1ps
module chip8_instruction_executor_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [12:0] i_cfg_program_end,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic        o_executed,
    input  logic [11:0] o_program_counter,
    input  logic [15:0] o_fetched_opcode,
    input  logic [11:0] o_index_value,
    input  logic [7:0]  o_read_value,
    input  logic [7:0]  o_delay_count,
    input  logic [7:0]  o_sound_count,
    input  logic        o_beep,
    input  logic        o_clear_screen,
    input  logic        o_unknown_opcode,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic        executed;
        logic [11:0] pc;
        logic [15:0] opcode;
        logic [11:0] index;
        logic [7:0]  rd;
        logic [7:0]  delay;
        logic [7:0]  sound;
        logic        beep;
        logic        clear;
        logic        unknown;
    } t_status;

    // Shadow copy of the machine state.
    logic [7:0]                 mem [c8x_pkg::MEM_BYTES];
    logic [7:0]                 vreg [16];
    logic [c8x_pkg::ADDR_W-1:0] stk [c8x_pkg::STACK_DEPTH];
    logic [c8x_pkg::SP_W-1:0]   sp;
    logic [c8x_pkg::ADDR_W-1:0] pc;
    logic [c8x_pkg::ADDR_W-1:0] idx;
    logic [15:0]                opcode;
    logic [7:0]                 dly;
    logic [7:0]                 snd;
    logic [12:0]                prog_end;
    t_status                    status_q [$];
    int                         errors;

    initial begin
        errors = 0;
        foreach (mem[a]) mem[a] = 8'd0;
        foreach (stk[a]) stk[a] = '0;
    end

    // Runs the opcode held in the shadow state; returns 1 for clear, 2 for unknown.
    function automatic int run_opcode();
        logic [3:0]                 x;
        logic [3:0]                 y;
        logic [7:0]                 nn;
        logic [11:0]                nnn;
        logic [7:0]                 vx;
        logic [7:0]                 vy;
        logic [c8x_pkg::ADDR_W-1:0] nxt;
        logic [8:0]                 sum;
        int                         flag;
        x = opcode[11:8];
        y = opcode[7:4];
        nn = opcode[7:0];
        nnn = opcode[11:0];
        vx = vreg[x];
        vy = vreg[y];
        nxt = pc + 12'd2;
        flag = 0;
        case (opcode[15:12])
            4'h0: begin
                if (nnn == 12'h0E0) begin
                    flag = 1;
                end else if (nnn == 12'h0EE) begin
                    sp = sp - 1'b1;
                    nxt = stk[sp];
                end
            end
            4'h1: nxt = nnn;
            4'h2: begin
                stk[sp] = nxt;
                sp = sp + 1'b1;
                nxt = nnn;
            end
            4'h3: if (vx == nn) nxt = nxt + 12'd2;
            4'h4: if (vx != nn) nxt = nxt + 12'd2;
            4'h5: if (vx == vy) nxt = nxt + 12'd2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vx + nn;
            4'h8: begin
                case (opcode[3:0])
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    4'h5, 4'h7: ;
                    4'h6: begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    4'hE: begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: flag = 2;
                endcase
            end
            4'h9: if (vx != vy) nxt = nxt + 12'd2;
            4'hA: idx = nnn;
            4'hB, 4'hC, 4'hD: ;
            4'hE: if (nn != 8'h9E && nn != 8'hA1) flag = 2;
            default: begin
                case (nn)
                    8'h07: vreg[x] = dly;
                    8'h15: dly = vx;
                    8'h18: snd = vx;
                    8'h1E: idx = idx + {4'd0, vx};
                    8'h33: begin
                        mem[idx] = vx / 8'd100;
                        mem[idx + 12'd1] = (vx / 8'd10) % 8'd10;
                        mem[idx + 12'd2] = vx % 8'd10;
                    end
                    8'h0A, 8'h29, 8'h55, 8'h65: ;
                    default: flag = 2;
                endcase
            end
        endcase
        pc = nxt;
        return flag;
    endfunction

    // Works out the result of one accepted request.
    function automatic t_status predict_status(logic [1:0] mode, logic [11:0] addr,
                                               logic [7:0] wbyte);
        t_status s;
        int      f;
        s = '0;
        if (mode == c8x_pkg::MODE_WRITE) begin
            mem[addr] = wbyte;
        end else if (mode == c8x_pkg::MODE_READ) begin
            s.rd = mem[addr];
        end else if (mode == c8x_pkg::MODE_REG) begin
            s.rd = vreg[addr[3:0]];
        end else if (pc < c8x_pkg::FETCH_LIMIT && {1'b0, pc} < prog_end) begin
            opcode = {mem[pc], mem[pc + 12'd1]};
            f = run_opcode();
            s.executed = 1'b1;
            s.clear = (f == 1);
            s.unknown = (f == 2);
            if (dly != 0) dly = dly - 1'b1;
            if (snd != 0) begin
                s.beep = (snd == 8'd1);
                snd = snd - 1'b1;
            end
        end
        s.pc = pc;
        s.opcode = opcode;
        s.index = idx;
        s.delay = dly;
        s.sound = snd;
        return s;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $realtime, name,
                     want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_status want;
        if (!i_rst_n) begin
            foreach (vreg[r]) vreg[r] = 8'd0;
            sp = '0;
            pc = c8x_pkg::PROGRAM_START;
            idx = '0;
            opcode = '0;
            dly = '0;
            snd = '0;
            prog_end = '0;
            status_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) prog_end = i_cfg_program_end;
            if (i_valid && o_ready)
                status_q.push_back(predict_status(i_mode, i_address, i_write_byte));
            // Compare each result with the oldest one outstanding.
            if (o_valid && i_ready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result with no request outstanding", $realtime);
                    errors++;
                end else begin
                    want = status_q.pop_front();
                    check_field("executed", want.executed, o_executed);
                    check_field("program_counter", want.pc, o_program_counter);
                    check_field("fetched_opcode", want.opcode, o_fetched_opcode);
                    check_field("index_value", want.index, o_index_value);
                    check_field("read_value", want.rd, o_read_value);
                    check_field("delay_count", want.delay, o_delay_count);
                    check_field("sound_count", want.sound, o_sound_count);
                    check_field("beep", want.beep, o_beep);
                    check_field("clear_screen", want.clear, o_clear_screen);
                    check_field("unknown_opcode", want.unknown, o_unknown_opcode);
                end
            end
        end
        o_pending <= status_q.size();
        o_errors <= errors;
    end

endmodule

[test/chip8_instruction_executor_tb.sv]
// Testbench top for the CHIP-8 instruction executor: clock, reset, requests and
// the verdict. Depends on c8x_pkg, the block and chip8_instruction_executor_chk.
`timescale 1ns / 1ps
module chip8_instruction_executor_tb;

    localparam int STALL_LIMIT = 20000;
    localparam logic [11:0] LOOP_BASE = 12'h200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_program_end = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = c8x_pkg::MODE_WRITE;
    logic [11:0] i_address = '0;
    logic [7:0]  i_write_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_executed;
    logic [11:0] o_program_counter;
    logic [15:0] o_fetched_opcode;
    logic [11:0] o_index_value;
    logic [7:0]  o_read_value;
    logic [7:0]  o_delay_count;
    logic [7:0]  o_sound_count;
    logic        o_beep;
    logic        o_clear_screen;
    logic        o_unknown_opcode;
    int          fail_count;
    int          pending;
    int          cyc = 0;
    int          hold = 0;
    int          quiet = 0;
    logic        calm;

    always #5 i_clk = ~i_clk;

    chip8_instruction_executor uut (.*);

    chip8_instruction_executor_chk checker_i (
        .*,
        .o_errors (fail_count),
        .o_pending(pending)
    );

    // A stretch with no idling on either side.
    assign calm = (cyc >= 1800 && cyc < 2600);

    // Result side: random stalls, and one long hold-off while requests keep coming.
    always @(posedge i_clk) begin
        cyc++;
        if (hold > 0) begin
            hold--;
            i_ready <= 1'b0;
        end else if (cyc == 1000) begin
            hold = 400;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] mode, logic [11:0] addr, logic [7:0] wbyte);
        if (!calm && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_address <= addr;
        i_write_byte <= wbyte;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic store_opcode(logic [11:0] addr, logic [15:0] op);
        send_request(c8x_pkg::MODE_WRITE, addr, op[15:8]);
        send_request(c8x_pkg::MODE_WRITE, addr + 12'd1, op[7:0]);
    endtask

    // Waits for every result, then writes the program end.
    task automatic set_program_end(logic [12:0] value);
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_program_end <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [11:0] loop_target();
        return LOOP_BASE + 12'(2 * $urandom_range(0, 31));
    endfunction

    // Mostly well-formed opcodes whose jumps stay inside the program loop. The index
    // register is only loaded with addresses above the program, so BCD stores never
    // land on opcodes.
    function automatic logic [15:0] random_opcode();
        logic [3:0] x;
        logic [3:0] y;
        logic [7:0] nn;
        logic [7:0] fsel [10];
        x = 4'($urandom);
        y = 4'($urandom);
        nn = 8'($urandom);
        fsel = '{8'h07, 8'h15, 8'h18, 8'h33, 8'h0A, 8'h29, 8'h55, 8'h65, 8'h33,
                 (nn == 8'h1E) ? 8'h00 : nn};
        case ($urandom_range(0, 17))
            0:  return 16'h00E0;
            1:  return 16'h00EE;
            2:  return {4'h1, loop_target()};
            3:  return {4'h2, loop_target()};
            4:  return {4'h3, x, nn};
            5:  return {4'h4, x, nn};
            6:  return {4'h5, x, y, 4'($urandom)};
            7, 8: return {4'h6, x, nn};
            9:  return {4'h7, x, nn};
            10, 11: return {4'h8, x, y, 4'($urandom)};
            12: return {4'h9, x, y, 4'($urandom)};
            13: return {4'hA, 4'h3, nn};
            14: return {4'hB + 4'($urandom_range(0, 2)), x, nn};
            15: return {4'hE, x, $urandom_range(0, 2) == 0 ? nn : ($urandom_range(0, 1) ?
                        8'h9E : 8'hA1)};
            16: return {4'hF, x, fsel[$urandom_range(0, 9)]};
            default: return {4'h0, 12'($urandom)};
        endcase
    endfunction

    // Reads stay inside the program area, which is always written.
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            send_request(c8x_pkg::MODE_RUN, 12'($urandom), 8'($urandom));
        else if (pick < 90)
            send_request(c8x_pkg::MODE_REG, 12'($urandom), 8'($urandom));
        else
            send_request(c8x_pkg::MODE_READ, LOOP_BASE + 12'(7'($urandom)), 8'($urandom));
    endtask

    initial begin
        logic [15:0] directed [];
        logic [12:0] ends [6];
        int          k;
        directed = '{16'h60FF, 16'h6101, 16'h8014, 16'h6FFF, 16'h8F14, 16'h6281, 16'h8206,
                     16'h820E, 16'h8123, 16'h8121, 16'h8122, 16'h8120, 16'h3000,
                     16'h4000, 16'h5010, 16'h9011, 16'h7AFF, 16'hAFFE, 16'h6AFF,
                     16'hFA33, 16'hFA1E, 16'h6302, 16'hF315, 16'hF318, 16'hF307,
                     16'h00E0, 16'h8128, 16'hE1FF, 16'hF1FF, 16'hD123, 16'h00EE};
        ends = '{13'h240, 13'h1000, 13'h0, 13'h0FFF, 13'h241, 13'h1FFF};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Guard jumps back to the loop just past the directed opcodes.
        for (int a = 12'h25E; a < 12'h280; a++)
            send_request(c8x_pkg::MODE_WRITE, 12'(a), (a % 2 == 0) ? 8'h12 : 8'h00);

        // Sixteen chained calls fill every stack entry, then the directed opcodes.
        for (int c = 0; c < 16; c++)
            store_opcode(LOOP_BASE + 12'(2 * c), {4'h2, LOOP_BASE + 12'(2 * c + 2)});
        foreach (directed[d])
            store_opcode(LOOP_BASE + 12'h20 + 12'(2 * d), directed[d]);

        // Program end still zero after reset: nothing is fetched.
        send_request(c8x_pkg::MODE_RUN, 12'h000, 8'h00);
        send_request(c8x_pkg::MODE_RUN, 12'hFFF, 8'hFF);
        set_program_end(13'h1000);
        for (k = 0; k < 52; k++) send_request(c8x_pkg::MODE_RUN, 12'h000, 8'h00);
        for (k = 0; k < 16; k++)
            send_request(c8x_pkg::MODE_REG, {8'($urandom), 4'(k)}, 8'h00);
        // Both bytes were stored by the BCD opcode, which wraps past the top.
        send_request(c8x_pkg::MODE_READ, 12'hFFF, 8'h00);
        send_request(c8x_pkg::MODE_READ, 12'h000, 8'h00);

        // Random phases, each under its own program end.
        for (int ph = 0; ph < 14; ph++) begin
            set_program_end(ph < 6 ? ends[ph] : ($urandom_range(0, 2) == 0 ?
                            13'($urandom) : 13'h240));
            for (k = 0; k < 4; k++) store_opcode(loop_target(), random_opcode());
            for (k = 0; k < 30; k++) random_item();
        end

        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/c8x_pkg.sv
rtl/core/c8x_memory.sv
rtl/core/c8x_stack.sv
rtl/core/chip8_instruction_executor.sv
test/chip8_instruction_executor_chk.sv
test/chip8_instruction_executor_tb.sv
